// File: src/vzd_pkg.sv
package vzd_pkg;

   localparam int unsigned WORD_W      = 64;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned GROUP_W     = 7;
   localparam int unsigned CONT_BIT    = 7;
   localparam int unsigned COUNT_W     = 4;
   localparam int unsigned SHIFT_W     = 6;
   localparam logic [COUNT_W-1:0] LAST_GROUP = COUNT_W'(9);

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DANGLING  = 2'd1,
      STATUS_TRUNCATED = 2'd2,
      STATUS_OVERLONG  = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              last_byte;
   } item_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] point_x;
      logic signed [WORD_W-1:0] point_y;
      logic                     point_valid;
      logic                     blob_end;
      status_type               end_status;
   } result_type;

   function automatic logic [WORD_W-1:0] unzigzag(input logic [WORD_W-1:0] v);
      return (v >> 1) ^ {WORD_W{v[0]}};
   endfunction

endpackage

// File: src/vzd_in_stage.sv
module vzd_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vzd_pkg::item_type req_item,
   input  logic              advance,
   output logic              item_valid,
   output vzd_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   vzd_pkg::item_type item_ff;
   logic              load;

   assign req_ready  = !valid_ff || advance;
   assign load       = req_valid && req_ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

endmodule

// File: src/vzd_core.sv
module vzd_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  vzd_pkg::item_type   item,
   output logic                has_result,
   output vzd_pkg::result_type result
);

   logic [vzd_pkg::WORD_W-1:0]  accum_ff, accum_in;
   logic [vzd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        expect_y_ff, expect_y_in;
   logic [vzd_pkg::WORD_W-1:0]  held_dx_ff, held_dx_in;
   logic [vzd_pkg::WORD_W-1:0]  sum_x_ff, sum_x_in;
   logic [vzd_pkg::WORD_W-1:0]  sum_y_ff, sum_y_in;
   vzd_pkg::status_type         error_ff, error_in;

   logic [vzd_pkg::SHIFT_W-1:0] shamt;
   logic [6:0]                  shift_full;
   logic [vzd_pkg::WORD_W-1:0]  accum_or;
   logic [vzd_pkg::WORD_W-1:0]  delta;
   logic                        point;
   logic                        open;

   assign shift_full = 7'(count_ff) * 7'(vzd_pkg::GROUP_W);
   assign shamt      = shift_full[vzd_pkg::SHIFT_W-1:0];
   assign accum_or   = accum_ff
                     | (vzd_pkg::WORD_W'(item.byte_value[vzd_pkg::GROUP_W-1:0]) << shamt);
   assign delta      = vzd_pkg::unzigzag(accum_or);

   always_comb begin
      accum_in    = accum_ff;
      count_in    = count_ff;
      expect_y_in = expect_y_ff;
      held_dx_in  = held_dx_ff;
      sum_x_in    = sum_x_ff;
      sum_y_in    = sum_y_ff;
      error_in    = error_ff;
      point       = 1'b0;
      open        = 1'b0;
      if (error_ff == vzd_pkg::STATUS_OK) begin
         if (item.byte_value[vzd_pkg::CONT_BIT]) begin
            accum_in = accum_or;
            if (count_ff == vzd_pkg::LAST_GROUP) begin
               error_in = vzd_pkg::STATUS_OVERLONG;
            end else begin
               count_in = count_ff + vzd_pkg::COUNT_W'(1);
               open     = 1'b1;
            end
         end else begin
            accum_in = '0;
            count_in = '0;
            if (!expect_y_ff) begin
               held_dx_in  = delta;
               expect_y_in = 1'b1;
            end else begin
               sum_x_in    = sum_x_ff + held_dx_ff;
               sum_y_in    = sum_y_ff + delta;
               held_dx_in  = '0;
               expect_y_in = 1'b0;
               point       = 1'b1;
            end
         end
      end
   end

   always_comb begin
      has_result         = point || item.last_byte;
      result.point_x     = point ? sum_x_in : '0;
      result.point_y     = point ? sum_y_in : '0;
      result.point_valid = point;
      result.blob_end    = item.last_byte;
      if (!item.last_byte) begin
         result.end_status = vzd_pkg::STATUS_OK;
      end else if (error_in != vzd_pkg::STATUS_OK) begin
         result.end_status = error_in;
      end else if (open) begin
         result.end_status = vzd_pkg::STATUS_TRUNCATED;
      end else if (expect_y_in) begin
         result.end_status = vzd_pkg::STATUS_DANGLING;
      end else begin
         result.end_status = vzd_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff    <= '0;
         count_ff    <= '0;
         expect_y_ff <= 1'b0;
         held_dx_ff  <= '0;
         sum_x_ff    <= '0;
         sum_y_ff    <= '0;
         error_ff    <= vzd_pkg::STATUS_OK;
      end else if (fire) begin
         if (item.last_byte) begin
            accum_ff    <= '0;
            count_ff    <= '0;
            expect_y_ff <= 1'b0;
            held_dx_ff  <= '0;
            sum_x_ff    <= '0;
            sum_y_ff    <= '0;
            error_ff    <= vzd_pkg::STATUS_OK;
         end else begin
            accum_ff    <= accum_in;
            count_ff    <= count_in;
            expect_y_ff <= expect_y_in;
            held_dx_ff  <= held_dx_in;
            sum_x_ff    <= sum_x_in;
            sum_y_ff    <= sum_y_in;
            error_ff    <= error_in;
         end
      end
   end

   count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= vzd_pkg::LAST_GROUP)
      else $error("varint byte count past limit");

   error_stops_count: assert property (@(posedge clock) disable iff (reset)
      (error_ff != vzd_pkg::STATUS_OK) && !(fire && item.last_byte)
      |=> $stable(count_ff) && $stable(sum_x_ff))
      else $error("state moved after error");

endmodule

// File: src/vzd_out_stage.sv
module vzd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  vzd_pkg::result_type result,
   output logic                space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output vzd_pkg::result_type rsp_result
);

   logic                valid_ff;
   logic                valid_in;
   vzd_pkg::result_type result_ff;

   assign space      = !valid_ff || rsp_ready;
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   no_point_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !result_ff.point_valid
      |-> result_ff.point_x == '0 && result_ff.point_y == '0)
      else $error("point fields set without point");

   status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !result_ff.blob_end |-> result_ff.end_status == vzd_pkg::STATUS_OK)
      else $error("status on word that is not blob end");

   error_no_point: assert property (@(posedge clock) disable iff (reset)
      valid_ff && result_ff.end_status != vzd_pkg::STATUS_OK |-> !result_ff.point_valid)
      else $error("point given with error status");

   no_overrun: assert property (@(posedge clock) disable iff (reset)
      load |-> space)
      else $error("result register overwritten");

endmodule

// File: src/varint_zigzag_delta_point_decoder_unit.sv
// Channel   Ports                                   Direction  Word
// req       req_valid/req_ready, req_byte_value,   in         one blob byte
//           req_last_byte
// rsp       rsp_valid/rsp_ready, rsp_point_*,      out        point and/or end status
//           rsp_blob_end, rsp_end_status
//
// One byte per cycle while no result stalls; a result is registered before it is offered.
// Latency is set by the input register and the result register around the decode logic.
// Reset clears blob state and both stage valids; the decoder then waits for a new blob.
// A stalled result holds the byte in the input register; bytes with no result still pass.
module varint_zigzag_delta_point_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [63:0] rsp_point_x,
   output logic signed [63:0] rsp_point_y,
   output logic        rsp_point_valid,
   output logic        rsp_blob_end,
   output logic [1:0]  rsp_end_status
);

   vzd_pkg::item_type   req_item;
   vzd_pkg::item_type   item;
   logic                item_valid;
   logic                advance;
   logic                has_result;
   logic                space;
   vzd_pkg::result_type result;
   vzd_pkg::result_type rsp_result;

   assign req_item.byte_value = req_byte_value;
   assign req_item.last_byte  = req_last_byte;
   assign advance = item_valid && (!has_result || space);

   vzd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   vzd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .item       (item),
      .has_result (has_result),
      .result     (result)
   );

   vzd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && has_result),
      .result     (result),
      .space      (space),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_point_x     = rsp_result.point_x;
   assign rsp_point_y     = rsp_result.point_y;
   assign rsp_point_valid = rsp_result.point_valid;
   assign rsp_blob_end    = rsp_result.blob_end;
   assign rsp_end_status  = rsp_result.end_status;

endmodule
